### hw/rtl/fol_pkg.sv
package fol_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned ACNT_W = 16;
  localparam int unsigned USED_W = 7;

  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_LOCATE = 1'b1;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_MISS     = 2'd1,
    ST_APPENDED = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

endpackage

### hw/rtl/frequency_ordered_list_lookup_top.sv
// Channel   Direction  Transfer when        Payload
// command   in         start_i & !busy_o    mode_i, key_i
// result    out        done_o               status_o, position_o, access_count_o,
//                                           entries_used_o
//
// Append, a full-table append and a locate on an empty table are answered from
// the idle state and leave busy_o low. A locate walks the table from the front
// through the single registered read port, one entry a cycle, then walks back
// from the hit, shifting one entry a cycle until it meets a larger count or the
// front. A miss ends once the last used entry has been compared.
// Reset clears the entry count, the sequencer, the read-valid flag and the result
// strobe only; entries above the count are never read, so the table memory needs
// no clearing pass. The result strobe lasts one cycle and cannot be stalled.
module frequency_ordered_list_lookup_top #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              mode_i,
  input  logic signed [fol_pkg::KEY_W-1:0]  key_i,
  output logic                              done_o,
  output fol_pkg::status_e                  status_o,
  output logic [fol_pkg::POS_W-1:0]         position_o,
  output logic [fol_pkg::ACNT_W-1:0]        access_count_o,
  output logic [fol_pkg::USED_W-1:0]        entries_used_o
);

  import fol_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned UW = $clog2(DEPTH + 1);
  localparam int unsigned CW = COUNT_BITS;
  localparam int unsigned DW = KEY_W + CW;

  // sequencer codes
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SRCH  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_INS   = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [UW-1:0]           used_q, used_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [UW-1:0]           rd_ptr_q, rd_ptr_d;   // next search address to issue
  logic [IW-1:0]           cmp_ptr_q, cmp_ptr_d; // address of the data on the read port
  logic                    dvld_q, dvld_d;       // search data on the read port is live
  logic [IW-1:0]           p_q, p_d;             // entry under test while shifting

  logic                    done_q, done_d;
  status_e                 status_q, status_d;
  logic [IW-1:0]           pos_q, pos_d;
  logic [CW-1:0]           acnt_q, acnt_d;

  logic                    ram_we, ram_re;
  logic [IW-1:0]           ram_waddr, ram_raddr;
  logic [DW-1:0]           ram_wdata, ram_rdata;

  logic signed [KEY_W-1:0] rd_key;
  logic [CW-1:0]           rd_cnt, hit_cnt;
  logic                    accept, issue;
  logic [31:0]             pos_ext, acnt_ext, used_ext;

  fol_ram #(
    .WIDTH(DW),
    .DEPTH(DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_key  = ram_rdata[DW-1 -: KEY_W];
  assign rd_cnt  = ram_rdata[CW-1:0];
  // saturate at the top of the count
  assign hit_cnt = (&rd_cnt) ? rd_cnt : CW'(rd_cnt + 1'b1);

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;
  assign issue  = (rd_ptr_q < used_q);

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    key_d     = key_q;
    cnt_d     = cnt_q;
    rd_ptr_d  = rd_ptr_q;
    cmp_ptr_d = cmp_ptr_q;
    dvld_d    = dvld_q;
    p_d       = p_q;
    done_d    = 1'b0;
    status_d  = status_q;
    pos_d     = pos_q;
    acnt_d    = acnt_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (mode_i == MODE_APPEND) begin
            done_d = 1'b1;
            acnt_d = '0;
            if (used_q == UW'(DEPTH)) begin
              status_d = ST_FULL;
              pos_d    = '0;
            end else begin
              // write the new entry straight at the end of the table
              ram_we    = 1'b1;
              ram_waddr = used_q[IW-1:0];
              ram_wdata = {key_i, CW'(0)};
              used_d    = UW'(used_q + 1'b1);
              status_d  = ST_APPENDED;
              pos_d     = used_q[IW-1:0];
            end
          end else begin
            key_d = key_i;
            if (used_q == '0) begin
              done_d   = 1'b1;
              status_d = ST_MISS;
              pos_d    = '0;
              acnt_d   = '0;
            end else begin
              state_d  = S_SRCH;
              rd_ptr_d = '0;
              dvld_d   = 1'b0;
            end
          end
        end
      end

      S_SRCH: begin
        // keep one read in flight ahead of the compare
        dvld_d = issue;
        if (issue) begin
          ram_re    = 1'b1;
          ram_raddr = rd_ptr_q[IW-1:0];
          rd_ptr_d  = UW'(rd_ptr_q + 1'b1);
          cmp_ptr_d = rd_ptr_q[IW-1:0];
        end
        if (dvld_q) begin
          if (rd_key == key_q) begin
            cnt_d  = hit_cnt;
            dvld_d = 1'b0;
            if (cmp_ptr_q == '0) begin
              state_d = S_INS;
              p_d     = '0;
            end else begin
              // drop the search read, fetch the entry just ahead of the hit
              ram_re    = 1'b1;
              ram_raddr = IW'(cmp_ptr_q - 1'b1);
              p_d       = IW'(cmp_ptr_q - 1'b1);
              state_d   = S_SHIFT;
            end
          end else if (UW'(UW'(cmp_ptr_q) + 1'b1) == used_q) begin
            state_d  = S_IDLE;
            dvld_d   = 1'b0;
            done_d   = 1'b1;
            status_d = ST_MISS;
            pos_d    = '0;
            acnt_d   = '0;
          end
        end
      end

      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(p_q + 1'b1);
        if (rd_cnt <= cnt_q) begin
          // move this entry back one place and keep walking forward
          ram_wdata = ram_rdata;
          if (p_q == '0) begin
            state_d = S_INS;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = IW'(p_q - 1'b1);
            p_d       = IW'(p_q - 1'b1);
          end
        end else begin
          ram_wdata = {key_q, cnt_q};
          state_d   = S_IDLE;
          done_d    = 1'b1;
          status_d  = ST_FOUND;
          pos_d     = IW'(p_q + 1'b1);
          acnt_d    = cnt_q;
        end
      end

      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = p_q;
        ram_wdata = {key_q, cnt_q};
        state_d   = S_IDLE;
        done_d    = 1'b1;
        status_d  = ST_FOUND;
        pos_d     = p_q;
        acnt_d    = cnt_q;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      dvld_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      dvld_q  <= dvld_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    cnt_q     <= cnt_d;
    rd_ptr_q  <= rd_ptr_d;
    cmp_ptr_q <= cmp_ptr_d;
    p_q       <= p_d;
    status_q  <= status_d;
    pos_q     <= pos_d;
    acnt_q    <= acnt_d;
  end

  // mask internal widths down to the result fields
  assign pos_ext  = 32'(pos_q);
  assign acnt_ext = 32'(acnt_q);
  assign used_ext = 32'(used_q);

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign position_o     = pos_ext[POS_W-1:0];
  assign access_count_o = acnt_ext[ACNT_W-1:0];
  assign entries_used_o = used_ext[USED_W-1:0];

  // the table holds no more than DEPTH entries
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(DEPTH))
    else $error("entry count above table depth");

  // an idle sequencer writes the table only for an accepted append
  a_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && ram_we) |-> (start_i && mode_i == MODE_APPEND))
    else $error("table write while idle without append");

  // the shift target always stays inside the used part of the table
  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (UW'(UW'(p_q) + 1'b1) < used_q))
    else $error("shift outside used entries");

  // a shift step keeps the entry count unchanged on the next cycle
  a_shift_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |=> $stable(used_q))
    else $error("entry count changed during a locate");

endmodule

### hw/rtl/fol_ram.sv
module fol_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fol_pkg::*;

  // Block configuration under test; the predictor follows the same sizes.
  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned COUNT_BITS  = 16;
  localparam int unsigned COUNT_TOP   = (1 << COUNT_BITS) - 1;

  // A deepest locate searches and shifts across the whole table; the run is called
  // hung only well beyond that, and a full locate settles after the last result.
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 2 * TABLE_DEPTH + 16;
  localparam int unsigned MAX_PRINTED  = 40;
  localparam int unsigned HOT_REPEATS  = 20;

  typedef struct packed {
    status_e             status;
    logic [POS_W-1:0]    position;
    logic [ACNT_W-1:0]   count;
    logic [USED_W-1:0]   used;
  } lookup_result_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic                     mode_i;
  logic signed [KEY_W-1:0]  key_i;
  logic                     done_o;
  status_e                  status_o;
  logic [POS_W-1:0]         position_o;
  logic [ACNT_W-1:0]        access_count_o;
  logic [USED_W-1:0]        entries_used_o;

  frequency_ordered_list_lookup_top #(
    .DEPTH      (TABLE_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .key_i          (key_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .position_o     (position_o),
    .access_count_o (access_count_o),
    .entries_used_o (entries_used_o)
  );

  // Shadow copy of the ordered table, advanced once per accepted command.
  logic [KEY_W-1:0]      table_keys   [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] table_counts [TABLE_DEPTH];
  int unsigned           table_used;

  // Results owed by the block, oldest first.
  lookup_result_t pending_results [$];

  // Keys the stimulus has put into the table, in append order. Kept on the
  // stimulus side so that the choice of the next key never depends on the order
  // in which the monitor and the stimulus run.
  logic [KEY_W-1:0] known_keys [$];

  int unsigned error_count;
  int unsigned stall_cycles;
  bit          idle_enabled;

  // Free-running clock, 2 ns period.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Count and print a mismatch; cap the printout, keep counting.
  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // Apply one command to the shadow table and return the result it owes.
  function automatic lookup_result_t apply_to_table(input logic mode,
                                                    input logic [KEY_W-1:0] key);
    lookup_result_t        res;
    int                    hit;
    int                    dst;
    logic [COUNT_BITS-1:0] cnt;
    res = '0;
    if (mode == MODE_APPEND) begin
      if (table_used >= TABLE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        table_keys[table_used]   = key;
        table_counts[table_used] = '0;
        res.status   = ST_APPENDED;
        res.position = table_used[POS_W-1:0];
        table_used++;
      end
    end else begin
      // Search from the front; only valid entries are looked at.
      hit = -1;
      for (int i = 0; i < int'(table_used); i++) begin
        if (hit < 0 && table_keys[i] == key) hit = i;
      end
      if (hit < 0) begin
        res.status = ST_MISS;
      end else begin
        cnt = table_counts[hit];
        if (cnt != COUNT_TOP[COUNT_BITS-1:0]) cnt++;
        // Move ahead of every earlier entry whose count does not exceed ours.
        dst = hit;
        while (dst > 0 && table_counts[dst-1] <= cnt) dst--;
        for (int k = hit; k > dst; k--) begin
          table_keys[k]   = table_keys[k-1];
          table_counts[k] = table_counts[k-1];
        end
        table_keys[dst]   = key;
        table_counts[dst] = cnt;
        res.status   = ST_FOUND;
        res.position = dst[POS_W-1:0];
        res.count    = ACNT_W'(cnt);
      end
    end
    res.used = table_used[USED_W-1:0];
    return res;
  endfunction

  // Monitor: at each rising edge, check a result first, then record a new
  // command transfer. A result can never belong to the command taken at the
  // same edge, so this order keeps the queue honest.
  always @(posedge clk_i) begin : monitor
    lookup_result_t want;
    bit             moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (done_o) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: status %0d pos %0d",
                                    status_o, position_o));
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", status_o, want.status));
          if (position_o !== want.position)
            report_mismatch($sformatf("position got %0d want %0d",
                                      position_o, want.position));
          if (access_count_o !== want.count)
            report_mismatch($sformatf("access_count got %0d want %0d",
                                      access_count_o, want.count));
          if (entries_used_o !== want.used)
            report_mismatch($sformatf("entries_used got %0d want %0d",
                                      entries_used_o, want.used));
        end
      end
      if (start_i && !busy_o) begin
        moved = 1'b1;
        pending_results.push_back(apply_to_table(mode_i, key_i));
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  // Watchdog: end the run when no transfer has happened for too long.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("[%0t] no transfer for %0d cycles", $realtime, STALL_LIMIT);
    $display("testbench: errors");
    $finish;
  end

  // Drive one command and hold it until the block takes it. Leave start high
  // on return, so a following command goes out back to back.
  task automatic issue_command(input logic mode, input logic [KEY_W-1:0] key);
    start_i <= 1'b1;
    mode_i  <= mode;
    key_i   <= key;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  task automatic append_key(input logic [KEY_W-1:0] key);
    if (known_keys.size() < TABLE_DEPTH) known_keys.push_back(key);
    issue_command(MODE_APPEND, key);
  endtask

  // Drop start for an idle burst of the given length and toggle the payload
  // meanwhile; the block must ignore it.
  task automatic idle_burst(input int unsigned n);
    repeat (n) begin
      start_i <= 1'b0;
      mode_i  <= 1'($urandom);
      key_i   <= $urandom;
      @(posedge clk_i);
    end
  endtask

  task automatic maybe_idle();
    if (idle_enabled && $urandom_range(0, 99) < 30) idle_burst($urandom_range(1, 7));
  endtask

  // Hold off the sender until every owed result has arrived. Advance the clock
  // first so the command taken at this edge is already queued.
  task automatic wait_results_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Pick a key already in the table; lean toward the late appends now and
  // then so that searches run deep.
  function automatic logic [KEY_W-1:0] pick_known_key();
    int unsigned n;
    n = known_keys.size();
    if (n == 0) return $urandom;
    if ($urandom_range(0, 3) == 0) return known_keys[$urandom_range(n - 1 - (n - 1) / 4, n - 1)];
    return known_keys[$urandom_range(0, n - 1)];
  endfunction

  // Extreme keys, the empty table, duplicates, misses and moves.
  task automatic test_directed_cases();
    idle_enabled = 1'b1;
    issue_command(MODE_LOCATE, 32'h0000_0000);   // empty table
    maybe_idle();
    append_key(32'h8000_0000);
    append_key(32'h7FFF_FFFF);
    append_key(32'h0000_0000);
    append_key(32'hFFFF_FFFF);
    append_key(32'h7FFF_FFFF);                   // duplicate key
    maybe_idle();
    issue_command(MODE_LOCATE, 32'h7FFF_FFFF);   // first match moves to front
    issue_command(MODE_LOCATE, 32'h7FFF_FFFF);
    maybe_idle();
    issue_command(MODE_LOCATE, 32'hFFFF_FFFF);   // stops behind a larger count
    issue_command(MODE_LOCATE, 32'h0000_0000);   // passes an equal count
    issue_command(MODE_LOCATE, 32'h8000_0000);
    maybe_idle();
    issue_command(MODE_LOCATE, 32'h1234_5678);   // miss
    issue_command(MODE_LOCATE, 32'h7FFF_FFFE);   // near miss
    append_key(32'h5555_5555);
    append_key(32'hAAAA_AAAA);
    issue_command(MODE_LOCATE, 32'hAAAA_AAAA);   // last entry
    issue_command(MODE_LOCATE, 32'h5555_5555);
    wait_results_drained();
    issue_command(MODE_LOCATE, 32'h8000_0000);
    issue_command(MODE_LOCATE, 32'hFFFF_FFFF);
    maybe_idle();
  endtask

  // Random mix while the table fills: mostly hits, some appends and misses,
  // with the occasional full drain.
  task automatic test_growing_table();
    int unsigned pick;
    for (int n = 0; n < 560; n++) begin
      if (n % 64 == 0) idle_enabled = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        if (known_keys.size() != 0 && $urandom_range(0, 9) == 0) append_key(pick_known_key());
        else append_key($urandom);
      end else if (pick < 90) begin
        issue_command(MODE_LOCATE, pick_known_key());
      end else begin
        issue_command(MODE_LOCATE, $urandom);
      end
      if (n % 150 == 149) wait_results_drained();
      else maybe_idle();
    end
    // Top the table up so that the next phase always sees it full.
    while (known_keys.size() < TABLE_DEPTH) begin
      append_key($urandom);
      maybe_idle();
    end
  endtask

  // Full table: appends are refused, hits land anywhere in the order.
  task automatic test_full_table();
    int unsigned pick;
    for (int n = 0; n < 520; n++) begin
      if (n % 64 == 0) idle_enabled = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 6) issue_command(MODE_APPEND, $urandom);
      else if (pick < 92) issue_command(MODE_LOCATE, pick_known_key());
      else issue_command(MODE_LOCATE, $urandom);
      maybe_idle();
    end
  endtask

  // Hammer two keys back to back with no idling, so their counts climb and
  // they trade places near the front of the table.
  task automatic test_hot_pair();
    logic [KEY_W-1:0] hot_key;
    logic [KEY_W-1:0] rival_key;
    idle_enabled = 1'b0;
    hot_key   = known_keys[0];
    rival_key = hot_key;
    foreach (known_keys[i]) begin
      if (rival_key == hot_key) rival_key = known_keys[i];
    end
    repeat (HOT_REPEATS) issue_command(MODE_LOCATE, hot_key);
    repeat (HOT_REPEATS) issue_command(MODE_LOCATE, rival_key);
    repeat (3) issue_command(MODE_LOCATE, hot_key);
    issue_command(MODE_LOCATE, rival_key);
    issue_command(MODE_APPEND, 32'h0F0F_0F0F);
  endtask

  initial begin
    error_count  = 0;
    table_used   = 0;
    idle_enabled = 1'b0;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    mode_i  = MODE_APPEND;
    key_i   = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_growing_table();
    test_full_table();
    test_hot_pair();

    // Drop start, collect what is still owed, then let the block settle.
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/fol_pkg.sv
hw/rtl/fol_ram.sv
hw/rtl/frequency_ordered_list_lookup_top.sv
tb/testbench.sv
